FILE: rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Result kind codes shared by the front end and the top level.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam logic [1:0] KIND_LINE      = 2'd0;
  localparam logic [1:0] KIND_SEGMENT   = 2'd1;
  localparam logic [1:0] KIND_PARALLEL  = 2'd2;
  localparam logic [1:0] KIND_COLLINEAR = 2'd3;

endpackage

FILE: rtl/sit_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step for the x and y quotients; registered towards the next cell.
// ----------------------------------------------------------------------------
module sit_div_cell #(
  parameter int DW = 35,
  parameter int QW = 51
) (
  input  logic          clk,
  input  logic [DW-1:0] d_in,
  input  logic [DW-1:0] rem_x_in,
  input  logic [QW-1:0] num_x_in,
  input  logic [QW-1:0] quo_x_in,
  input  logic [DW-1:0] rem_y_in,
  input  logic [QW-1:0] num_y_in,
  input  logic [QW-1:0] quo_y_in,
  output logic [DW-1:0] d_out,
  output logic [DW-1:0] rem_x_out,
  output logic [QW-1:0] num_x_out,
  output logic [QW-1:0] quo_x_out,
  output logic [DW-1:0] rem_y_out,
  output logic [QW-1:0] num_y_out,
  output logic [QW-1:0] quo_y_out
);

  logic [DW:0]   trial_x, trial_y, diff_x, diff_y;
  logic          ge_x, ge_y;

  always_comb begin
    trial_x = {rem_x_in, num_x_in[QW-1]};
    trial_y = {rem_y_in, num_y_in[QW-1]};
    diff_x  = trial_x - {1'b0, d_in};
    diff_y  = trial_y - {1'b0, d_in};
    ge_x    = trial_x >= {1'b0, d_in};
    ge_y    = trial_y >= {1'b0, d_in};
  end

  always_ff @(posedge clk) begin
    d_out     <= d_in;
    rem_x_out <= ge_x ? diff_x[DW-1:0] : trial_x[DW-1:0];
    rem_y_out <= ge_y ? diff_y[DW-1:0] : trial_y[DW-1:0];
    num_x_out <= {num_x_in[QW-2:0], 1'b0};
    num_y_out <= {num_y_in[QW-2:0], 1'b0};
    quo_x_out <= {quo_x_in[QW-2:0], ge_x};
    quo_y_out <= {quo_y_in[QW-2:0], ge_y};
  end

endmodule

FILE: rtl/sit_cross.sv
// ----------------------------------------------------------------------------
// Cross product front end
// Differences, cross products, hit classification and the two dividends.
// ----------------------------------------------------------------------------
module sit_cross #(
  parameter int W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  logic signed [W-1:0]   x1, y1, x2, y2, x3, y3, x4, y4,
  input  logic                  incl,
  output logic                  out_vld,
  output logic signed [3*W+3:0] num_x,
  output logic signed [3*W+3:0] num_y,
  output logic signed [2*W+2:0] den,
  output logic [1:0]            kind,
  output logic                  den_zero,
  output logic signed [W-1:0]   base_x,
  output logic signed [W-1:0]   base_y
);

  localparam int DFW = W + 1;
  localparam int PRW = 2 * DFW;
  localparam int NW  = 2 * W + 3;

  logic                  v1, v2, v3;
  logic signed [DFW-1:0] dx1, dy1, dx2, dy2, ox, oy;
  logic signed [DFW-1:0] dx1_2, dy1_2, dx1_3, dy1_3;
  logic signed [W-1:0]   x1_1, y1_1, x1_2, y1_2, x1_3, y1_3;
  logic                  incl_1, incl_2, incl_3;
  logic signed [PRW-1:0] pa, pb, pc, pd, pe, pf;
  logic signed [NW-1:0]  d3, n1_3, n2_3;
  logic [NW-1:0]         ad, an1, an2;
  logic                  in1, in2;

  always_comb begin
    ad  = d3[NW-1] ? NW'(-d3) : NW'(d3);
    an1 = n1_3[NW-1] ? NW'(-n1_3) : NW'(n1_3);
    an2 = n2_3[NW-1] ? NW'(-n2_3) : NW'(n2_3);
    if (n1_3 == '0) begin
      in1 = incl_3;
    end else if (n1_3[NW-1] != d3[NW-1]) begin
      in1 = 1'b0;
    end else begin
      in1 = incl_3 ? (an1 <= ad) : (an1 < ad);
    end
    if (n2_3 == '0) begin
      in2 = incl_3;
    end else if (n2_3[NW-1] != d3[NW-1]) begin
      in2 = 1'b0;
    end else begin
      in2 = incl_3 ? (an2 <= ad) : (an2 < ad);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dx1    <= {x2[W-1], x2} - {x1[W-1], x1};
    dy1    <= {y2[W-1], y2} - {y1[W-1], y1};
    dx2    <= {x4[W-1], x4} - {x3[W-1], x3};
    dy2    <= {y4[W-1], y4} - {y3[W-1], y3};
    ox     <= {x1[W-1], x1} - {x3[W-1], x3};
    oy     <= {y1[W-1], y1} - {y3[W-1], y3};
    x1_1   <= x1;
    y1_1   <= y1;
    incl_1 <= incl;

    pa     <= dy2 * dx1;
    pb     <= dx2 * dy1;
    pc     <= dx2 * oy;
    pd     <= dy2 * ox;
    pe     <= dx1 * oy;
    pf     <= dy1 * ox;
    dx1_2  <= dx1;
    dy1_2  <= dy1;
    x1_2   <= x1_1;
    y1_2   <= y1_1;
    incl_2 <= incl_1;

    d3     <= {pa[PRW-1], pa} - {pb[PRW-1], pb};
    n1_3   <= {pc[PRW-1], pc} - {pd[PRW-1], pd};
    n2_3   <= {pe[PRW-1], pe} - {pf[PRW-1], pf};
    dx1_3  <= dx1_2;
    dy1_3  <= dy1_2;
    x1_3   <= x1_2;
    y1_3   <= y1_2;
    incl_3 <= incl_2;

    num_x    <= n1_3 * dx1_3;
    num_y    <= n1_3 * dy1_3;
    den      <= d3;
    den_zero <= (d3 == '0);
    base_x   <= x1_3;
    base_y   <= y1_3;
    if (d3 == '0) begin
      kind <= (n1_3 == '0 && n2_3 == '0) ? sit_pkg::KIND_COLLINEAR : sit_pkg::KIND_PARALLEL;
    end else begin
      kind <= (in1 && in2) ? sit_pkg::KIND_SEGMENT : sit_pkg::KIND_LINE;
    end
  end

endmodule

FILE: rtl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// Segment intersection test
// Classifies two segments and computes their crossing point as signed integers (Q32.0).
// ----------------------------------------------------------------------------
// Usage: drive the eight endpoints and inclusive_ends with start high; the
// transfer is taken at any edge where busy is low. busy is high only while
// rst is asserted, so a new pair may be offered in every cycle.
// The result appears with done high for exactly one cycle and is taken at the
// edge that follows. Its path from the transfer holds 3*COORD_WIDTH+8 register
// stages: four difference, product and classification stages, one stage per
// quotient bit in the chain of divider cells, and a final saturation stage.
// Throughput is one pair per clock outside reset; results keep arrival order.
// Reset clears all valid flags in the pipeline; pairs in flight are dropped.
// The receiver cannot stall the block, so results must be taken as they come.
// Parallel and collinear pairs give a zero point and clipped low.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_WIDTH-1:0] seg1_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg1_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg1_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg1_end_y,
  input  logic signed [COORD_WIDTH-1:0] seg2_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg2_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg2_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg2_end_y,
  input  logic                         inclusive_ends,
  output logic                         done,
  output logic [1:0]                   hit_kind,
  output logic signed [31:0]           cross_x,
  output logic signed [31:0]           cross_y,
  output logic                         clipped
);

  localparam int W   = COORD_WIDTH;
  localparam int QPW = 3 * W + 4;
  localparam int QW  = QPW - 1;
  localparam int DW  = 2 * W + 3;
  localparam int PW  = (QW + 2 > 33) ? QW + 2 : 33;

  logic                  f_vld, f_dz;
  logic signed [QPW-1:0] f_nx, f_ny;
  logic signed [DW-1:0]  f_den;
  logic [1:0]            f_kind;
  logic signed [W-1:0]   f_bx, f_by;

  logic [DW-1:0] c_d     [0:QW];
  logic [DW-1:0] c_rem_x [0:QW];
  logic [QW-1:0] c_num_x [0:QW];
  logic [QW-1:0] c_quo_x [0:QW];
  logic [DW-1:0] c_rem_y [0:QW];
  logic [QW-1:0] c_num_y [0:QW];
  logic [QW-1:0] c_quo_y [0:QW];

  logic                 sb_vld  [0:QW-1];
  logic [1:0]           sb_kind [0:QW-1];
  logic                 sb_dz   [0:QW-1];
  logic                 sb_sx   [0:QW-1];
  logic                 sb_sy   [0:QW-1];
  logic signed [W-1:0]  sb_bx   [0:QW-1];
  logic signed [W-1:0]  sb_by   [0:QW-1];

  logic signed [PW-1:0] px, py;
  logic                 ok_x, ok_y;

  assign busy = rst;

  sit_cross #(.W(W)) u_cross (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start && !busy),
    .x1       (seg1_start_x),
    .y1       (seg1_start_y),
    .x2       (seg1_end_x),
    .y2       (seg1_end_y),
    .x3       (seg2_start_x),
    .y3       (seg2_start_y),
    .x4       (seg2_end_x),
    .y4       (seg2_end_y),
    .incl     (inclusive_ends),
    .out_vld  (f_vld),
    .num_x    (f_nx),
    .num_y    (f_ny),
    .den      (f_den),
    .kind     (f_kind),
    .den_zero (f_dz),
    .base_x   (f_bx),
    .base_y   (f_by)
  );

  // The dividend magnitudes always fit one bit below the signed product width.
  always_comb begin
    c_d[0]     = f_den[DW-1] ? DW'(-f_den) : DW'(f_den);
    c_rem_x[0] = '0;
    c_rem_y[0] = '0;
    c_num_x[0] = f_nx[QPW-1] ? QW'(-f_nx) : QW'(f_nx);
    c_num_y[0] = f_ny[QPW-1] ? QW'(-f_ny) : QW'(f_ny);
    c_quo_x[0] = '0;
    c_quo_y[0] = '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    sit_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk       (clk),
      .d_in      (c_d[i]),
      .rem_x_in  (c_rem_x[i]),
      .num_x_in  (c_num_x[i]),
      .quo_x_in  (c_quo_x[i]),
      .rem_y_in  (c_rem_y[i]),
      .num_y_in  (c_num_y[i]),
      .quo_y_in  (c_quo_y[i]),
      .d_out     (c_d[i+1]),
      .rem_x_out (c_rem_x[i+1]),
      .num_x_out (c_num_x[i+1]),
      .quo_x_out (c_quo_x[i+1]),
      .rem_y_out (c_rem_y[i+1]),
      .num_y_out (c_num_y[i+1]),
      .quo_y_out (c_quo_y[i+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sb_vld[i] <= 1'b0;
      end else begin
        sb_vld[i] <= (i == 0) ? f_vld : sb_vld[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (i == 0) begin
        sb_kind[i] <= f_kind;
        sb_dz[i]   <= f_dz;
        sb_sx[i]   <= f_nx[QPW-1] ^ f_den[DW-1];
        sb_sy[i]   <= f_ny[QPW-1] ^ f_den[DW-1];
        sb_bx[i]   <= f_bx;
        sb_by[i]   <= f_by;
      end else begin
        sb_kind[i] <= sb_kind[(i == 0) ? 0 : i-1];
        sb_dz[i]   <= sb_dz[(i == 0) ? 0 : i-1];
        sb_sx[i]   <= sb_sx[(i == 0) ? 0 : i-1];
        sb_sy[i]   <= sb_sy[(i == 0) ? 0 : i-1];
        sb_bx[i]   <= sb_bx[(i == 0) ? 0 : i-1];
        sb_by[i]   <= sb_by[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_comb begin
    px = PW'(sb_bx[QW-1]) + (sb_sx[QW-1] ? -PW'(c_quo_x[QW]) : PW'(c_quo_x[QW]));
    py = PW'(sb_by[QW-1]) + (sb_sy[QW-1] ? -PW'(c_quo_y[QW]) : PW'(c_quo_y[QW]));
    ok_x = (&px[PW-1:31]) || !(|px[PW-1:31]);
    ok_y = (&py[PW-1:31]) || !(|py[PW-1:31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sb_vld[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    hit_kind <= sb_kind[QW-1];
    if (sb_dz[QW-1]) begin
      cross_x <= '0;
      cross_y <= '0;
      clipped <= 1'b0;
    end else begin
      cross_x <= ok_x ? px[31:0] : (px[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
      cross_y <= ok_y ? py[31:0] : (py[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
      clipped <= !(ok_x && ok_y);
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    f_vld |-> ##(QW+1) done)
    else $error("result strobe missing after divider chain");
  a_no_line: assert property (@(posedge clk) disable iff (rst)
    done && (hit_kind == sit_pkg::KIND_PARALLEL || hit_kind == sit_pkg::KIND_COLLINEAR)
    |-> cross_x == 0 && cross_y == 0 && !clipped)
    else $error("degenerate pair produced a point");
  a_kind_dz: assert property (@(posedge clk) disable iff (rst)
    f_vld |-> (f_dz == (f_kind == sit_pkg::KIND_PARALLEL ||
                        f_kind == sit_pkg::KIND_COLLINEAR)))
    else $error("kind disagrees with zero denominator");
`endif

endmodule

FILE: sim/tb_segment_intersection_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Feeds segment pairs with random gaps between transfers, works out the kind,
// crossing point and clip flag of each pair independently, and compares every
// result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test;

  localparam int CW        = 16;
  localparam int LATENCY   = 3 * CW + 8;
  localparam int CYCLE_MAX = 300000;

  typedef struct {
    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic                 incl;
  } seg_pair_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               clip;
  } crossing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] seg1_start_x = '0, seg1_start_y = '0, seg1_end_x = '0, seg1_end_y = '0;
  logic signed [CW-1:0] seg2_start_x = '0, seg2_start_y = '0, seg2_end_x = '0, seg2_end_y = '0;
  logic inclusive_ends = 1'b0;
  logic done;
  logic [1:0] hit_kind;
  logic signed [31:0] cross_x, cross_y;
  logic clipped;

  crossing_t pending_crossings[$];
  int error_count = 0;
  int cycle_count = 0;

  segment_intersection_test #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seg1_start_x(seg1_start_x), .seg1_start_y(seg1_start_y),
    .seg1_end_x(seg1_end_x), .seg1_end_y(seg1_end_y),
    .seg2_start_x(seg2_start_x), .seg2_start_y(seg2_start_y),
    .seg2_end_x(seg2_end_x), .seg2_end_y(seg2_end_y),
    .inclusive_ends(inclusive_ends), .done(done), .hit_kind(hit_kind),
    .cross_x(cross_x), .cross_y(cross_y), .clipped(clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // A parameter n/den lies inside the unit interval, judged by signs and magnitudes.
  function automatic bit param_inside(input longint n, input longint den, input bit incl);
    longint an, ad;
    if (n == 0) return incl;
    if ((n < 0) != (den < 0)) return 1'b0;
    an = (n < 0) ? -n : n;
    ad = (den < 0) ? -den : den;
    return incl ? (an <= ad) : (an < ad);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v, inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Products stay below 2^53 at this width, so 64-bit arithmetic is exact.
  function automatic crossing_t predict_crossing(input seg_pair_t p);
    crossing_t r;
    longint dx1, dy1, dx2, dy2, ox, oy, den, n1, n2;
    logic clip;
    dx1 = longint'(p.x2) - longint'(p.x1);
    dy1 = longint'(p.y2) - longint'(p.y1);
    dx2 = longint'(p.x4) - longint'(p.x3);
    dy2 = longint'(p.y4) - longint'(p.y3);
    ox  = longint'(p.x1) - longint'(p.x3);
    oy  = longint'(p.y1) - longint'(p.y3);
    den = dy2 * dx1 - dx2 * dy1;
    n1  = dx2 * oy - dy2 * ox;
    n2  = dx1 * oy - dy1 * ox;
    r = '{kind: sit_pkg::KIND_PARALLEL, px: '0, py: '0, clip: 1'b0};
    if (den == 0) begin
      if (n1 == 0 && n2 == 0) r.kind = sit_pkg::KIND_COLLINEAR;
      return r;
    end
    clip = 1'b0;
    r.px = clamp32(longint'(p.x1) + (n1 * dx1) / den, clip);
    r.py = clamp32(longint'(p.y1) + (n1 * dy1) / den, clip);
    r.clip = clip;
    r.kind = (param_inside(n1, den, p.incl) && param_inside(n2, den, p.incl))
             ? sit_pkg::KIND_SEGMENT : sit_pkg::KIND_LINE;
    return r;
  endfunction

  always @(posedge clk) begin
    crossing_t e;
    if (!rst && done) begin
      if (pending_crossings.size() == 0) begin
        report_mismatch("result with no outstanding prediction");
      end else begin
        e = pending_crossings.pop_front();
        if (hit_kind !== e.kind)
          report_mismatch($sformatf("hit_kind %0d, expected %0d", hit_kind, e.kind));
        if (cross_x !== e.px)
          report_mismatch($sformatf("cross_x %0d, expected %0d", cross_x, e.px));
        if (cross_y !== e.py)
          report_mismatch($sformatf("cross_y %0d, expected %0d", cross_y, e.py));
        if (clipped !== e.clip)
          report_mismatch($sformatf("clipped %0b, expected %0b", clipped, e.clip));
      end
    end
  end

  // Start is left high across back-to-back transfers.
  task automatic send_pair(input seg_pair_t p);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg1_start_x <= p.x1; seg1_start_y <= p.y1; seg1_end_x <= p.x2; seg1_end_y <= p.y2;
    seg2_start_x <= p.x3; seg2_start_y <= p.y3; seg2_end_x <= p.x4; seg2_end_y <= p.y4;
    inclusive_ends <= p.incl;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_crossings = {pending_crossings, predict_crossing(p)};
  endtask

  function automatic seg_pair_t make_pair(input int x1, y1, x2, y2, x3, y3, x4, y4,
                                          input bit incl);
    seg_pair_t p;
    p.x1 = CW'(x1); p.y1 = CW'(y1); p.x2 = CW'(x2); p.y2 = CW'(y2);
    p.x3 = CW'(x3); p.y3 = CW'(y3); p.x4 = CW'(x4); p.y4 = CW'(y4);
    p.incl = incl;
    return p;
  endfunction

  // A coordinate drawn evenly from -offset to span-offset.
  function automatic logic signed [CW-1:0] rand_coord(input int span, input int offset);
    return CW'(int'($urandom_range(0, span)) - offset);
  endfunction

  task automatic test_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    for (int i = 0; i < 2; i++) begin
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, i));                  // all degenerate
      send_pair(make_pair(0, 0, 160, 0, 0, 16, 160, 16, i));            // parallel
      send_pair(make_pair(0, 0, 160, 0, 32, 0, 320, 0, i));             // collinear
      send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, i));          // clean crossing
      send_pair(make_pair(0, 0, 160, 0, 0, -80, 0, 80, i));             // ua equal to zero
      send_pair(make_pair(0, 0, 160, 0, 160, -80, 160, 80, i));         // ua equal to one
      send_pair(make_pair(0, 0, 160, 0, 80, 0, 80, 80, i));             // ub equal to zero
      send_pair(make_pair(0, 0, 160, 0, 320, -80, 320, 80, i));         // line crossing only
      send_pair(make_pair(-32768, -32768, 32767, 32767,
                          -32768, 32767, 32767, -32768, i));             // extreme corners
      send_pair(make_pair(-32768, 0, 32767, 1,
                          -32768, -32768, 32766, -32767, i));            // saturating point
      send_pair(make_pair(32767, 0, -32768, -1,
                          32767, 32767, -32766, 32766, i));              // saturating the other way
    end
  endtask

  task automatic test_random();
    seg_pair_t p;
    int mode, k;
    for (int n = 0; n < 1300; n++) begin
      mode = $urandom_range(0, 9);
      for (int f = 0; f < 8; f++) begin
        case (f)
          0: p.x1 = CW'($urandom); 1: p.y1 = CW'($urandom);
          2: p.x2 = CW'($urandom); 3: p.y2 = CW'($urandom);
          4: p.x3 = CW'($urandom); 5: p.y3 = CW'($urandom);
          6: p.x4 = CW'($urandom); default: p.y4 = CW'($urandom);
        endcase
      end
      p.incl = 1'($urandom_range(0, 1));
      if (mode < 4) begin
        // Small coordinates: many true segment crossings and shared endpoints.
        p.x1 = rand_coord(8, 4); p.y1 = rand_coord(8, 4);
        p.x2 = rand_coord(8, 4); p.y2 = rand_coord(8, 4);
        p.x3 = rand_coord(8, 4); p.y3 = rand_coord(8, 4);
        p.x4 = rand_coord(8, 4); p.y4 = rand_coord(8, 4);
      end else if (mode == 4) begin
        // Second segment is the first one shifted: parallel or collinear.
        k = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 64)) - 32;
        p.x1 = rand_coord(2000, 1000); p.y1 = rand_coord(2000, 1000);
        p.x2 = rand_coord(2000, 1000); p.y2 = rand_coord(2000, 1000);
        p.x3 = CW'(int'(p.x1) + k); p.y3 = CW'(int'(p.y1) + k);
        p.x4 = CW'(int'(p.x2) + k); p.y4 = CW'(int'(p.y2) + k);
      end else if (mode == 5) begin
        // Nearly parallel long lines, to drive the point far out.
        p.y2 = CW'(int'(p.y1) + int'($urandom_range(0, 4)) - 2);
        p.x4 = CW'(int'(p.x3) + (int'(p.x2) - int'(p.x1)) + int'($urandom_range(0, 2)) - 1);
        p.y4 = CW'(int'(p.y3) + (int'(p.y2) - int'(p.y1)) + int'($urandom_range(0, 2)) - 1);
      end
      send_pair(p);
    end
  endtask

  task automatic test_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  initial begin
    test_reset();
    test_directed();
    test_random();
    test_drain();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
